FILE: design/bepq_pkg.sv
// Package for the bucketed event priority queue: sizes, codes, bundles.
// Used by bepq_ctrl, bepq_dp and bucketed_event_priority_queue.
package bepq_pkg;
  localparam int unsigned Entries = 256;
  localparam int unsigned Buckets = 64;
  localparam int unsigned HW = $clog2(Entries);
  localparam int unsigned BW = $clog2(Buckets);
  localparam int unsigned CntW = HW + 1;

  localparam logic [2:0] ModeInsert = 3'd0;
  localparam logic [2:0] ModeRemove = 3'd1;
  localparam logic [2:0] ModeExtract = 3'd2;
  localparam logic [2:0] ModePeek = 3'd3;
  localparam logic [2:0] ModeClear = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StDup = 2'd2;
  localparam logic [1:0] StAbsent = 2'd3;

  localparam logic [1:0] CfgFloor = 2'd0;
  localparam logic [1:0] CfgScale = 2'd1;
  localparam logic [1:0] CfgCount = 2'd2;

  // Datapath command issued by the controller each cycle.
  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdBucket, CmdHeadRd, CmdWalkRd, CmdWalkChk,
    CmdInsLink, CmdRemLink, CmdMinRd, CmdMinChk, CmdMinOut, CmdClear,
    CmdResult
  } cmd_e;

  typedef struct packed {
    logic [2:0] mode;
    logic       queued;      // the addressed handle is queued
    logic       cnt_zero;
    logic       cur_nil;     // current walk pointer is null
    logic       go_after;    // new entry sorts behind current
    logic       cur_is_h;    // current walk pointer is the handle
    logic       min_nil;     // head of lowest bucket is null
    logic       min_last;    // lowest bucket is the last bucket
  } dp_status_t;
endpackage

FILE: design/bepq_dp.sv
// Datapath of the queue: entry memories, bucket heads, list walk registers.
// Depends on bepq_pkg; driven by bepq_ctrl.
module bepq_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bepq_pkg::cmd_e        cmd_i,
  input  logic [1:0]            res_st_i,
  input  logic [2:0]            mode_i,
  input  logic [7:0]            handle_i,
  input  logic [31:0]           key_y_i,
  input  logic [31:0]           key_x_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  output bepq_pkg::dp_status_t  st_o,
  output logic [1:0]            status_o,
  output logic [7:0]            out_handle_o,
  output logic [31:0]           out_y_o,
  output logic [31:0]           out_x_o,
  output logic [8:0]            entry_count_o
);
  import bepq_pkg::*;

  logic [31:0] floor_q, scale_q;
  logic [6:0]  nbuck_q;
  logic [Buckets-1:0] head_vld_q;   // set while the bucket list is not empty
  logic [Entries-1:0] queued_q;
  logic [CntW-1:0] cnt_q;
  logic [BW-1:0] low_q;
  // Memories. A head entry is only meaningful while its valid bit is set.
  logic [HW-1:0] head_m [Buckets];
  logic [HW:0]  link_m [Entries];
  logic [31:0]  y_m [Entries];
  logic [31:0]  x_m [Entries];
  logic [BW-1:0] bk_m [Entries];

  logic [2:0]  mode_q;
  logic [HW-1:0] h_q;
  logic [31:0] ky_q, kx_q;
  logic [BW-1:0] b_q;
  logic [HW:0] cur_q, prev_q, lnk_q;
  logic [31:0] cy_q, cx_q;
  logic [63:0] prod_q;
  logic signed [32:0] diff_q;
  logic [HW-1:0] minh_q;

  // bucket clamp
  logic [6:0] n_lim;
  logic [BW-1:0] bclamp;
  always_comb begin
    n_lim = nbuck_q;
    if (n_lim == 7'd0) n_lim = 7'd1;
    if (n_lim > 7'(Buckets)) n_lim = 7'(Buckets);
    if (diff_q <= 0) bclamp = '0;
    else if (prod_q[63:32] > 32'(n_lim - 7'd1)) bclamp = BW'(n_lim - 7'd1);
    else bclamp = BW'(prod_q[63:32]);
  end

  // Bucket whose list is walked: computed for insert, recorded for remove.
  logic [BW-1:0] hb;
  assign hb = (mode_q == ModeInsert) ? bclamp : b_q;

  logic after;
  always_comb begin
    if (ky_q != cy_q) after = $signed(ky_q) > $signed(cy_q);
    else after = $signed(kx_q) > $signed(cx_q);
  end

  assign st_o.mode = mode_q;
  assign st_o.queued = queued_q[h_q];
  assign st_o.cnt_zero = (cnt_q == '0);
  assign st_o.cur_nil = cur_q[HW];
  assign st_o.go_after = after;
  assign st_o.cur_is_h = (cur_q == {1'b0, h_q});
  assign st_o.min_nil = !head_vld_q[low_q];
  assign st_o.min_last = (low_q == BW'(Buckets - 1));

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CmdLoad: begin
        mode_q <= mode_i; h_q <= HW'(handle_i); ky_q <= key_y_i; kx_q <= key_x_i;
        diff_q <= $signed({key_y_i[31], key_y_i}) - $signed({floor_q[31], floor_q});
      end
      CmdBucket: begin
        prod_q <= {32'd0, diff_q[31:0]} * {32'd0, scale_q};
        b_q <= bk_m[h_q];
      end
      CmdHeadRd: begin
        b_q <= hb;
        cur_q <= {!head_vld_q[hb], head_m[hb]};
        prev_q <= {1'b1, HW'(0)};
      end
      CmdWalkRd: begin
        cy_q <= y_m[cur_q[HW-1:0]]; cx_q <= x_m[cur_q[HW-1:0]];
        lnk_q <= link_m[cur_q[HW-1:0]];
      end
      CmdWalkChk: begin prev_q <= cur_q; cur_q <= lnk_q; end
      CmdInsLink: begin
        y_m[h_q] <= ky_q; x_m[h_q] <= kx_q; bk_m[h_q] <= b_q; link_m[h_q] <= cur_q;
        if (prev_q[HW]) head_m[b_q] <= h_q;
        else link_m[prev_q[HW-1:0]] <= {1'b0, h_q};
      end
      CmdRemLink: begin
        // The list is only relinked when the handle was found in its bucket.
        if (!cur_q[HW]) begin
          if (prev_q[HW]) head_m[b_q] <= lnk_q[HW-1:0];
          else link_m[prev_q[HW-1:0]] <= lnk_q;
        end
      end
      CmdMinRd: begin
        minh_q <= head_m[low_q];
        cur_q <= {1'b0, head_m[low_q]};
      end
      CmdMinOut: head_m[low_q] <= lnk_q[HW-1:0];
      CmdResult: begin
        status_o <= res_st_i;
        out_handle_o <= '0; out_y_o <= '0; out_x_o <= '0;
        if (res_st_i == StOk && (mode_q == ModeExtract || mode_q == ModePeek)) begin
          out_handle_o <= 8'(minh_q); out_y_o <= cy_q; out_x_o <= cx_q;
        end
        entry_count_o <= 9'(cnt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= '0; scale_q <= 32'd65536; nbuck_q <= 7'd64;
      head_vld_q <= '0;
      queued_q <= '0; cnt_q <= '0; low_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFloor: floor_q <= cfg_data_i;
          CfgScale: scale_q <= cfg_data_i;
          CfgCount: nbuck_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      case (cmd_i)
        CmdInsLink: begin
          head_vld_q[b_q] <= 1'b1;
          queued_q[h_q] <= 1'b1; cnt_q <= cnt_q + 1'b1;
          if (b_q < low_q) low_q <= b_q;
        end
        CmdRemLink: begin
          if (!cur_q[HW] && prev_q[HW]) head_vld_q[b_q] <= !lnk_q[HW];
          queued_q[h_q] <= 1'b0; cnt_q <= cnt_q - 1'b1;
        end
        CmdMinChk: low_q <= low_q + 1'b1;
        CmdMinOut: begin
          head_vld_q[low_q] <= !lnk_q[HW];
          queued_q[minh_q] <= 1'b0; cnt_q <= cnt_q - 1'b1;
        end
        CmdClear: begin
          head_vld_q <= '0;
          queued_q <= '0; cnt_q <= '0; low_q <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: design/bepq_ctrl.sv
// Controller state machine for the queue; sequences datapath commands.
// Depends on bepq_pkg.
module bepq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic                 out_free_i,
  input  bepq_pkg::dp_status_t st_i,
  output bepq_pkg::cmd_e       cmd_o,
  output logic [1:0]           res_st_o,
  output logic                 busy_o,
  output logic                 res_load_o
);
  import bepq_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SDec, SBuck, SHead, SWRd, SWChk, SRLink, SILink, SMin, SMinRd,
    SMinEnt, SMinOut, SRes, SWait
  } state_e;
  state_e state_q;
  logic [1:0] rst_q;

  always_comb begin
    cmd_o = CmdNone;
    res_load_o = 1'b0;
    unique case (state_q)
      SIdle: if (in_fire_i) cmd_o = CmdLoad;
      SDec: cmd_o = CmdBucket;
      SBuck: cmd_o = CmdNone;
      SHead: cmd_o = CmdHeadRd;
      SWRd: cmd_o = st_i.cur_nil ? CmdNone : CmdWalkRd;
      SWChk: if (!st_i.cur_nil) begin
        if (st_i.mode == ModeInsert ? st_i.go_after : !st_i.cur_is_h) cmd_o = CmdWalkChk;
      end
      SILink: cmd_o = CmdInsLink;
      SRLink: cmd_o = CmdRemLink;
      SMin: if (st_i.min_nil && !st_i.min_last) cmd_o = CmdMinChk;
      SMinRd: cmd_o = CmdMinRd;
      SMinEnt: cmd_o = CmdWalkRd;
      SMinOut: if (st_i.mode == ModeExtract) cmd_o = CmdMinOut;
      SRes: if (out_free_i) begin cmd_o = CmdResult; res_load_o = 1'b1; end
      SWait: cmd_o = CmdClear;
      default: ;
    endcase
  end

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; rst_q <= StOk;
    end else begin
      unique case (state_q)
        SIdle: if (in_fire_i) state_q <= SDec;
        SDec: begin
          rst_q <= StOk;
          state_q <= SRes;
          if (st_i.mode == ModeInsert) begin
            if (st_i.queued) rst_q <= StDup; else state_q <= SBuck;
          end else if (st_i.mode == ModeRemove) begin
            if (!st_i.queued) rst_q <= StAbsent; else state_q <= SHead;
          end else if (st_i.mode == ModeExtract || st_i.mode == ModePeek) begin
            if (st_i.cnt_zero) rst_q <= StEmpty; else state_q <= SMin;
          end else if (st_i.mode == ModeClear) begin
            state_q <= SWait;
          end
        end
        SWait: state_q <= SRes;
        SBuck: state_q <= SHead;
        SHead: state_q <= SWRd;
        SWRd: state_q <= st_i.cur_nil ? ((st_i.mode == ModeInsert) ? SILink : SRLink) : SWChk;
        SWChk: begin
          if (st_i.cur_nil) state_q <= (st_i.mode == ModeInsert) ? SILink : SRLink;
          else if (st_i.mode == ModeInsert ? st_i.go_after : !st_i.cur_is_h) state_q <= SWRd;
          else state_q <= (st_i.mode == ModeInsert) ? SILink : SRLink;
        end
        SILink: state_q <= SRes;
        SRLink: state_q <= SRes;
        SMin: if (!(st_i.min_nil && !st_i.min_last)) begin
          if (st_i.min_nil) begin rst_q <= StEmpty; state_q <= SRes; end
          else state_q <= SMinRd;
        end
        SMinRd: state_q <= SMinEnt;
        SMinEnt: state_q <= SMinOut;
        SMinOut: state_q <= SRes;
        SRes: if (out_free_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assign res_st_o = rst_q;

`ifndef SYNTH
  a_idle_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |-> state_q == SIdle) else $error("request taken while busy");
  a_res_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |=> state_q == SIdle) else $error("result without return to idle");
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |=> busy_o) else $error("not busy after request");
`endif
endmodule

FILE: design/bucketed_event_priority_queue.sv
// Bucketed event priority queue: one request in, one result out, sequenced.
// Top level; instantiates bepq_ctrl and bepq_dp, uses bepq_pkg.
//
// Entries (handle, key y, tie-break x) are filed in bucket
// floor((y - key_floor) * bucket_scale / 2^32) clamped to the buckets in use, each
// bucket a linked list sorted by (y, x). One request is worked on at a time.
// Each request is decoded and then sequenced: insert computes its bucket,
// reads the bucket head, walks the list (a read and a check per entry passed)
// and links the entry in; remove reads the recorded bucket, walks to the
// handle and unlinks it; peek and extract scan upward for the lowest bucket
// that is not empty, read its head entry and, for extract, unlink it; clear
// goes through a wait state that empties the queue; duplicate insert, absent
// remove and peek or extract on an empty count go straight to the result, as
// does an empty result found by the scan. The next request is accepted in the
// cycle after the result loads, while that result may still sit in the output
// register; a result that is not taken holds the controller until it is.
module bucketed_event_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // mode[2:0], handle[10:3], key_y[42:11], key_x[74:43]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // status[1:0], out_handle[9:2], out_y[41:10],
                                      // out_x[73:42], entry_count[82:74], queue_empty[83]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import bepq_pkg::*;

  cmd_e cmd;
  dp_status_t st;
  logic [1:0] res_st, status;
  logic busy, res_load, ovalid_q;
  logic [7:0] oh;
  logic [31:0] oy, ox;
  logic [8:0] cnt;

  // The output register is free when empty or being taken; a new result loads only then.
  wire out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = !busy;
  assign cfg_ready_o = 1'b1;

  bepq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(s_axis_tvalid && !busy), .out_free_i(out_free),
    .st_i(st), .cmd_o(cmd), .res_st_o(res_st), .busy_o(busy), .res_load_o(res_load)
  );

  bepq_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .res_st_i(res_st),
    .mode_i(s_axis_tdata[2:0]), .handle_i(s_axis_tdata[10:3]),
    .key_y_i(s_axis_tdata[42:11]), .key_x_i(s_axis_tdata[74:43]),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .st_o(st), .status_o(status), .out_handle_o(oh), .out_y_o(oy), .out_x_o(ox),
    .entry_count_o(cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (res_load) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {4'd0, (cnt == 9'd0), cnt, ox, oy, oh, status};

`ifndef SYNTH
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> ovalid_q) else $error("result dropped");
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (m_axis_tdata[83] == (m_axis_tdata[82:74] == 9'd0)))
    else $error("empty flag mismatch");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("double accept");
`endif
endmodule
